@@ hw/rtl/gmd_pkg.sv @@
// ----------------------------------------------------------------------------
// gmd_pkg: shared types and constants of the grid mass deposit block
// Holds the operation codes, register indexes, field widths and the
// controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package gmd_pkg;

  // Operation codes carried in the input tuser field.
  localparam logic [1:0] FN_DEPOSIT = 2'd0;
  localparam logic [1:0] FN_CLEAR   = 2'd1;
  localparam logic [1:0] FN_READ    = 2'd2;
  localparam logic [1:0] FN_NOP     = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL      = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // Field widths.
  localparam int unsigned AXIS_W    = 6;   // grid size and axis cell
  localparam int unsigned POS_W     = 16;
  localparam int unsigned MASS_W    = 32;
  localparam int unsigned LEVEL_W   = 5;
  localparam int unsigned CELL_W    = 15;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned DENS_W    = 40;
  localparam int unsigned PLANE_W   = 2 * AXIS_W;      // gx * gy
  localparam int unsigned IDX_W     = 3 * AXIS_W;      // linear index
  localparam int unsigned LIM_W     = IDX_W + 1;       // range compares
  localparam int unsigned WIDE_W    = 64;

  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 64;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_INDEX,
    ST_RMW
  } gmd_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/gmd_ram.sv @@
// ----------------------------------------------------------------------------
// gmd_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gmd_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 32768,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/grid_mass_deposit.sv @@
// ----------------------------------------------------------------------------
// grid_mass_deposit: nearest grid point mass deposit onto a 3-D density grid
// Scales particle coordinates to cells, forms the linear cell index and adds
// the particle mass with saturation into a cell memory; also clears the grid
// and reads back single cells.
// ----------------------------------------------------------------------------
// The block works on one transfer at a time. A deposit goes through axis
// scaling, index products, index sum with the memory read, then the add and
// write back before the block is ready again; a cell read goes through the
// index step with the memory read and the last step, a no-operation through
// the last step only. A grid clear sweeps the cell memory one entry per cycle
// through its single write port, then takes the last step. The last step of
// each waits while an earlier result still sits unaccepted in the result
// register. After reset the same sweep runs before the first input transfer
// is taken; configuration writes are taken throughout. The result register
// lets the next item be accepted while a result still waits on the output.
`default_nettype none

module grid_mass_deposit
  import gmd_pkg::*;
#(
  parameter int MAX_CELLS     = 32768,
  parameter int MASS_SUM_BITS = 40
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration write port.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input stream.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // Fields from bit 0: pos_x[16], pos_y[16], pos_z[16], particle_mass[32],
  // particle_live[1], particle_level[5], read_cell[15], zero fill[3].
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0: func[2].
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  // Result stream.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // Fields from bit 0: cell_density[40], cell_index[15], deposited[1],
  // saturated[1], zero fill[7].
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int SW = MASS_SUM_BITS;
  localparam logic [LIM_W-1:0] MAX_CELLS_W = LIM_W'(MAX_CELLS);
  localparam logic [AW-1:0]    LAST_CELL   = AW'(MAX_CELLS - 1);

  gmd_state_t state_r, state_nxt;

  // Configuration registers.
  logic [AXIS_W-1:0]  gx_r, gy_r, gz_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic [PLANE_W-1:0] gxy_r;

  // Captured item.
  logic [1:0]         func_r;
  logic [POS_W-1:0]   px_r, py_r, pz_r;
  logic [MASS_W-1:0]  mass_r;
  logic               live_r;
  logic [LEVEL_W-1:0] level_r;
  logic [CELL_W-1:0]  rc_r;

  // Index datapath.
  logic [AXIS_W-1:0]  ix_r, iy_r, iz_r;
  logic [AXIS_W-1:0]  tx_r;
  logic [PLANE_W-1:0] ty_r;
  logic [IDX_W-1:0]   tz_r;
  logic [IDX_W-1:0]   idx_r;
  logic               pass_r, hit_r, rd_ok_r;

  logic [AW-1:0]      clr_ptr_r;
  logic               clr_item_r;
  logic               clr_last;

  // Result register.
  logic               out_valid_r;
  logic [DENS_W-1:0]  out_dens_r;
  logic [CELL_W-1:0]  out_cell_r;
  logic               out_dep_r, out_sat_r;

  // Memory port.
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [SW-1:0]      ram_wdata, ram_rdata;

  logic               in_xfer, out_load;

  logic [2*AXIS_W+POS_W-AXIS_W-1:0] px_prod, py_prod, pz_prod;
  logic [IDX_W-1:0]   idx_w;
  logic               pass_w, dep_hit, rc_ok;
  logic [LIM_W-1:0]   rc_ext;
  logic [SW:0]        sum_w;
  logic               sum_sat;
  logic [SW-1:0]      sum_new;
  logic [WIDE_W-1:0]  dens_ext, rd_ext;
  logic [DENS_W-1:0]  res_dens;
  logic [CELL_W-1:0]  res_cell;
  logic               res_dep, res_sat;

  gmd_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_xfer  = in_tvalid && in_tready;
  assign clr_last = (clr_ptr_r == LAST_CELL);

  // Axis scaling: floor(pos * cells) is the top six bits of the product.
  assign px_prod = (POS_W+AXIS_W)'(px_r) * (POS_W+AXIS_W)'(gx_r);
  assign py_prod = (POS_W+AXIS_W)'(py_r) * (POS_W+AXIS_W)'(gy_r);
  assign pz_prod = (POS_W+AXIS_W)'(pz_r) * (POS_W+AXIS_W)'(gz_r);

  assign idx_w   = IDX_W'(tx_r) + IDX_W'(ty_r) + tz_r;
  assign pass_w  = live_r && (level_r == lvl_r);
  assign dep_hit = pass_w && (idx_w < IDX_W'(cnt_r)) && (LIM_W'(idx_w) < MAX_CELLS_W);
  assign rc_ext  = LIM_W'(rc_r);
  assign rc_ok   = rc_ext < MAX_CELLS_W;

  assign sum_w    = (SW+1)'(ram_rdata) + (SW+1)'(mass_r);
  assign sum_sat  = sum_w[SW];
  assign sum_new  = sum_sat ? {SW{1'b1}} : sum_w[SW-1:0];
  assign dens_ext = WIDE_W'(sum_new);
  assign rd_ext   = WIDE_W'(ram_rdata);

  always_comb begin
    res_dens = '0;
    res_cell = '0;
    res_dep  = 1'b0;
    res_sat  = 1'b0;
    case (func_r)
      FN_DEPOSIT: begin
        res_dens = hit_r ? dens_ext[DENS_W-1:0] : '0;
        res_cell = pass_r ? idx_r[CELL_W-1:0] : '0;
        res_dep  = hit_r;
        res_sat  = hit_r && sum_sat;
      end
      FN_READ: begin
        res_dens = rd_ok_r ? rd_ext[DENS_W-1:0] : '0;
        res_cell = rc_r;
      end
      default: begin
        res_dens = '0;
      end
    endcase
  end

  // Controller: next state, handshake and memory port.
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_ptr_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = idx_w[AW-1:0];
    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_last) begin
          state_nxt = clr_item_r ? ST_RMW : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_tuser)
            FN_DEPOSIT: state_nxt = ST_MUL;
            FN_CLEAR:   state_nxt = ST_CLEAR;
            FN_READ:    state_nxt = ST_INDEX;
            default:    state_nxt = ST_RMW;
          endcase
        end
      end
      ST_MUL: begin
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        state_nxt = ST_INDEX;
      end
      ST_INDEX: begin
        if (func_r == FN_READ) begin
          ram_re    = rc_ok;
          ram_raddr = rc_ext[AW-1:0];
        end else begin
          ram_re    = dep_hit;
          ram_raddr = idx_w[AW-1:0];
        end
        state_nxt = ST_RMW;
      end
      ST_RMW: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          ram_we    = (func_r == FN_DEPOSIT) && hit_r;
          ram_waddr = idx_r[AW-1:0];
          ram_wdata = sum_new;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers and sweep control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gx_r       <= AXIS_W'(32);
      gy_r       <= AXIS_W'(32);
      gz_r       <= AXIS_W'(32);
      cnt_r      <= COUNT_W'(32768);
      lvl_r      <= '0;
      clr_ptr_r  <= '0;
      clr_item_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_X:     gx_r  <= cfg_wdata[AXIS_W-1:0];
          CFG_GRID_Y:     gy_r  <= cfg_wdata[AXIS_W-1:0];
          CFG_GRID_Z:     gz_r  <= cfg_wdata[AXIS_W-1:0];
          CFG_CELL_COUNT: cnt_r <= cfg_wdata[COUNT_W-1:0];
          CFG_LEVEL:      lvl_r <= cfg_wdata[LEVEL_W-1:0];
          default:        lvl_r <= lvl_r;
        endcase
      end
      if (state_r == ST_CLEAR) begin
        clr_ptr_r <= clr_last ? '0 : clr_ptr_r + AW'(1);
      end
      if (in_xfer) begin
        clr_item_r <= (in_tuser == FN_CLEAR);
      end
    end
  end

  // Item capture and index datapath.
  always_ff @(posedge clk) begin
    gxy_r <= PLANE_W'(gx_r) * PLANE_W'(gy_r);
    if (in_xfer) begin
      func_r  <= in_tuser;
      px_r    <= in_tdata[15:0];
      py_r    <= in_tdata[31:16];
      pz_r    <= in_tdata[47:32];
      mass_r  <= in_tdata[79:48];
      live_r  <= in_tdata[80];
      level_r <= in_tdata[85:81];
      rc_r    <= in_tdata[100:86];
    end
    if (state_r == ST_MUL) begin
      ix_r <= px_prod[POS_W+AXIS_W-1:POS_W];
      iy_r <= py_prod[POS_W+AXIS_W-1:POS_W];
      iz_r <= pz_prod[POS_W+AXIS_W-1:POS_W];
    end
    if (state_r == ST_SCALE) begin
      tx_r <= ix_r;
      ty_r <= PLANE_W'(iy_r) * PLANE_W'(gx_r);
      tz_r <= IDX_W'(iz_r) * IDX_W'(gxy_r);
    end
    if (state_r == ST_INDEX) begin
      idx_r   <= idx_w;
      pass_r  <= pass_w;
      hit_r   <= dep_hit;
      rd_ok_r <= rc_ok;
    end
    if (out_load) begin
      out_dens_r <= res_dens;
      out_cell_r <= res_cell;
      out_dep_r  <= res_dep;
      out_sat_r  <= res_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_sat_r, out_dep_r, out_cell_r, out_dens_r};

`ifndef SYNTHESIS
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_RMW))
    else $error("grid memory written outside the clear sweep or write back");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("second item accepted while one is in flight");

  a_sat_dep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |-> out_dep_r)
    else $error("saturated result without a deposit");

  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && clr_last) |=> (state_r == ST_IDLE || state_r == ST_RMW))
    else $error("clear sweep did not finish");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_grid_mass_deposit.sv @@
// ----------------------------------------------------------------------------
// tb_grid_mass_deposit: self-checking testbench of the grid mass deposit block
// A queue-fed driver streams deposit, clear, read and no-operation transfers
// while a monitor checks every result against an in-bench density grid model.
// Register settings change between phases, and in all but the last phases
// both stream sides idle at random rates.
// ----------------------------------------------------------------------------
module tb_grid_mass_deposit;
  import gmd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GRID_DEPTH = 32768;
  localparam logic [40:0] SUM_LIMIT = 41'h0FF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [31:0] mass;
    logic        live;
    logic [4:0]  level;
    logic [14:0] read_cell;
  } particle_item_t;

  typedef struct packed {
    logic [39:0] density;
    logic [14:0] index;
    logic        deposited;
    logic        saturated;
  } cell_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  grid_mass_deposit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    // pos_x[16], pos_y[16], pos_z[16], particle_mass[32], particle_live[1],
    // particle_level[5], read_cell[15], zero fill[3].
    .in_tdata  (in_tdata),
    // func[2].
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    // cell_density[40], cell_index[15], deposited[1], saturated[1],
    // zero fill[7].
    .out_tdata (out_tdata)
  );

  logic [39:0] grid_model [0:GRID_DEPTH-1];
  logic [5:0]  m_gx = 6'd32;
  logic [5:0]  m_gy = 6'd32;
  logic [5:0]  m_gz = 6'd32;
  logic [15:0] m_cells = 16'h8000;
  logic [4:0]  m_level = 5'd0;

  particle_item_t pending_items[$];
  cell_result_t   cell_results_q[$];
  int unsigned    hot_cells[$];
  particle_item_t bus_item;
  cell_result_t   bus_pred;
  cell_result_t   mon_got;
  cell_result_t   mon_want;

  int send_idle = 21;
  int recv_idle = 49;
  int clears_left = 3;
  int errors = 0;
  int n_in = 0;
  int n_applied = 0;
  int n_sat = 0;
  int n_reads = 0;
  int n_clears = 0;
  int n_settings = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic cell_result_t predict_cell_result(particle_item_t it);
    cell_result_t r;
    int unsigned  gx, gy, gz, ix, iy, iz, idx;
    logic [40:0]  sum;
    r = '0;
    gx = m_gx;
    gy = m_gy;
    gz = m_gz;
    case (it.func)
      FN_DEPOSIT: begin
        if (it.live && it.level == m_level) begin
          ix = (int'(it.pos_x) * gx) >> 16;
          iy = (int'(it.pos_y) * gy) >> 16;
          iz = (int'(it.pos_z) * gz) >> 16;
          idx = ix + iy * gx + iz * gx * gy;
          r.index = idx[14:0];
          if (idx < m_cells && idx < GRID_DEPTH) begin
            sum = {1'b0, grid_model[idx]} + {9'b0, it.mass};
            if (sum > SUM_LIMIT) begin
              sum = SUM_LIMIT;
              r.saturated = 1'b1;
            end
            grid_model[idx] = sum[39:0];
            r.density = sum[39:0];
            r.deposited = 1'b1;
            hot_cells = {hot_cells, idx};
            if (hot_cells.size() > 64) void'(hot_cells.pop_front());
          end
        end
      end
      FN_CLEAR: begin
        for (int i = 0; i < GRID_DEPTH; i++) grid_model[i] = '0;
      end
      FN_READ: begin
        r.index = it.read_cell;
        r.density = grid_model[it.read_cell];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        bus_pred = predict_cell_result(bus_item);
        cell_results_q = {cell_results_q, bus_pred};
        n_in++;
        if (bus_pred.deposited) n_applied++;
        if (bus_pred.saturated) n_sat++;
        if (bus_item.func == FN_READ) n_reads++;
        if (bus_item.func == FN_CLEAR) n_clears++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          bus_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {3'b0, bus_item.read_cell, bus_item.level, bus_item.live,
                       bus_item.mass, bus_item.pos_z, bus_item.pos_y, bus_item.pos_x};
          in_tuser <= bus_item.func;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        mon_got.density = out_tdata[39:0];
        mon_got.index = out_tdata[54:40];
        mon_got.deposited = out_tdata[55];
        mon_got.saturated = out_tdata[56];
        if (cell_results_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("Unexpected result transfer: density %h index %0d dep %b sat %b",
                     mon_got.density, mon_got.index, mon_got.deposited, mon_got.saturated);
        end else begin
          mon_want = cell_results_q.pop_front();
          if (mon_got.density !== mon_want.density || mon_got.index !== mon_want.index ||
              mon_got.deposited !== mon_want.deposited ||
              mon_got.saturated !== mon_want.saturated) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch: expected density %h index %0d dep %b sat %b, got %h %0d %b %b",
                       mon_want.density, mon_want.index, mon_want.deposited,
                       mon_want.saturated, mon_got.density, mon_got.index,
                       mon_got.deposited, mon_got.saturated);
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  function automatic particle_item_t mk_item(logic [1:0] fn, logic [15:0] px, logic [15:0] py,
                                             logic [15:0] pz, logic [31:0] mass, logic live,
                                             logic [4:0] lvl, logic [14:0] rc);
    particle_item_t it;
    it.func = fn;
    it.pos_x = px;
    it.pos_y = py;
    it.pos_z = pz;
    it.mass = mass;
    it.live = live;
    it.level = lvl;
    it.read_cell = rc;
    return it;
  endfunction

  task automatic queue_item(particle_item_t it);
    pending_items = {pending_items, it};
  endtask

  function automatic logic [15:0] rand_pos();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || cell_results_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_GRID_X:     m_gx = val[5:0];
      CFG_GRID_Y:     m_gy = val[5:0];
      CFG_GRID_Z:     m_gz = val[5:0];
      CFG_CELL_COUNT: m_cells = val;
      CFG_LEVEL:      m_level = val[4:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(int gx, int gy, int gz, int cells, int lvl);
    write_reg(CFG_GRID_X, CFG_DATA_W'(gx));
    write_reg(CFG_GRID_Y, CFG_DATA_W'(gy));
    write_reg(CFG_GRID_Z, CFG_DATA_W'(gz));
    write_reg(CFG_CELL_COUNT, CFG_DATA_W'(cells));
    write_reg(CFG_LEVEL, CFG_DATA_W'(lvl));
    write_reg(CFG_IDX_W'(int'(CFG_LEVEL) + 1 + int'($urandom_range(0, 2))),
              CFG_DATA_W'($urandom_range(0, 65535)));
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic run_phase(int count, bit sat_mode);
    logic [1:0]  fn;
    logic [31:0] mass;
    logic        live;
    logic [4:0]  lvl;
    logic [14:0] rc;
    int          roll;
    int          dep_pct;
    dep_pct = sat_mode ? 90 : 70;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      roll = $urandom_range(0, 99);
      if (!sat_mode && clears_left > 0 && $urandom_range(0, 399) == 0) begin
        fn = FN_CLEAR;
        clears_left--;
      end else if (roll < dep_pct) begin
        fn = FN_DEPOSIT;
      end else if (roll < dep_pct + (sat_mode ? 7 : 22)) begin
        fn = FN_READ;
      end else begin
        fn = FN_NOP;
      end
      if ($urandom_range(0, 99) < (sat_mode ? 95 : 85)) begin
        live = 1'b1;
        lvl = m_level;
      end else begin
        live = 1'($urandom_range(0, 1));
        lvl = 5'($urandom_range(0, 31));
      end
      roll = $urandom_range(0, 99);
      if (sat_mode) mass = (roll < 95) ? 32'hFFFF_FFFF : $urandom;
      else if (roll < 5) mass = 32'h0;
      else if (roll < 10) mass = 32'hFFFF_FFFF;
      else mass = $urandom;
      if (hot_cells.size() != 0 && $urandom_range(0, 99) < 60)
        rc = 15'(hot_cells[$urandom_range(0, hot_cells.size() - 1)]);
      else
        rc = 15'($urandom_range(0, 32767));
      queue_item(mk_item(fn, rand_pos(), rand_pos(), rand_pos(), mass, live, lvl, rc));
    end
    wait_drained();
  endtask

  initial begin
    #20_000_000;
    $display("Timeout with %0d results still expected.", cell_results_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    for (int i = 0; i < GRID_DEPTH; i++) grid_model[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset register values.
    queue_item(mk_item(FN_READ, 0, 0, 0, 0, 0, 0, 0));
    queue_item(mk_item(FN_DEPOSIT, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 0));
    queue_item(mk_item(FN_DEPOSIT, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 15'h7FFF));
    queue_item(mk_item(FN_DEPOSIT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 0, 0));
    queue_item(mk_item(FN_READ, 0, 0, 0, 0, 0, 0, 15'h7FFF));
    queue_item(mk_item(FN_DEPOSIT, 16'h1234, 16'h4321, 16'h7777, 99, 0, 0, 0));
    queue_item(mk_item(FN_DEPOSIT, 16'h1234, 16'h4321, 16'h7777, 99, 1, 31, 0));
    queue_item(mk_item(FN_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1,
                       31, 15'h7FFF));
    queue_item(mk_item(FN_READ, 0, 0, 0, 0, 0, 0, 0));
    queue_item(mk_item(FN_DEPOSIT, 16'h8000, 16'h8000, 16'h8000, 0, 1, 0, 0));
    queue_item(mk_item(FN_CLEAR, 16'hFFFF, 0, 16'hFFFF, 32'h5555_AAAA, 1, 0, 5));
    queue_item(mk_item(FN_READ, 0, 0, 0, 0, 0, 0, 0));
    queue_item(mk_item(FN_READ, 0, 0, 0, 0, 0, 0, 15'h7FFF));
    wait_drained();

    // Largest sizes: indices beyond the grid are dropped.
    apply_setting(63, 63, 63, 65535, 31);
    queue_item(mk_item(FN_DEPOSIT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5, 1, 31, 0));
    queue_item(mk_item(FN_DEPOSIT, 0, 16'hFFFF, 0, 7, 1, 31, 0));
    queue_item(mk_item(FN_READ, 0, 0, 0, 0, 0, 0, 15'd3906));
    wait_drained();

    // Zero sizes and a zero cell count: everything lands on cell zero and is dropped.
    apply_setting(0, 0, 0, 0, 31);
    queue_item(mk_item(FN_DEPOSIT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9, 1, 31, 0));
    wait_drained();

    // The cell count bounds deposits but not reads.
    apply_setting(10, 10, 10, 100, 0);
    queue_item(mk_item(FN_DEPOSIT, 16'hFFFF, 16'hFFFF, 0, 11, 1, 0, 0));
    queue_item(mk_item(FN_DEPOSIT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 13, 1, 0, 0));
    queue_item(mk_item(FN_READ, 0, 0, 0, 0, 0, 0, 15'd99));
    queue_item(mk_item(FN_READ, 0, 0, 0, 0, 0, 0, 15'd999));
    wait_drained();

    apply_setting(32, 32, 32, 32768, $urandom_range(0, 31));
    run_phase(180, 1'b0);
    apply_setting(4, 4, 4, 64, 31);
    run_phase(180, 1'b0);

    send_idle = 49;
    recv_idle = 21;
    apply_setting(1, 1, 1, 1, 0);
    run_phase(400, 1'b1);
    apply_setting(63, 63, 63, 65535, $urandom_range(0, 31));
    run_phase(170, 1'b0);

    send_idle = 0;
    recv_idle = 0;
    apply_setting(5, 0, 7, 3, $urandom_range(0, 31));
    run_phase(170, 1'b0);
    apply_setting($urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 32),
                  $urandom_range(1, 32768), $urandom_range(0, 31));
    run_phase(170, 1'b0);
    apply_setting(17, 31, 9, 4000, $urandom_range(0, 31));
    run_phase(180, 1'b0);

    repeat (40) @(posedge clk);
    $display("Run covered %0d input transfers over %0d register settings, %0d deposits",
             n_in, n_settings, n_applied);
    $display("applied (%0d saturated), %0d cell reads and %0d grid clears; %0d failures.",
             n_sat, n_reads, n_clears, errors);
    if (errors == 0 && cell_results_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/gmd_pkg.sv
hw/rtl/gmd_ram.sv
hw/rtl/grid_mass_deposit.sv
tb/sv/tb_grid_mass_deposit.sv
